// ===== rtl/tvvd_pkg.sv =====
// ----------------------------------------------------------------------------
// Track voxel density package
// Shared types, codes and default dimensions for the voxel density block.
// ----------------------------------------------------------------------------
package tvvd_pkg;

    localparam int DefDimX      = 64;
    localparam int DefDimY      = 64;
    localparam int DefDimZ      = 64;
    localparam int DefCountBits = 16;

    localparam int CoordW  = 16;
    localparam int ReadW   = 6;
    localparam int OffW    = 10;
    localparam int VoxW    = 11;
    localparam int OutW    = 16;

    localparam logic [OffW-1:0] OffXReset = 10'd181;
    localparam logic [OffW-1:0] OffYReset = 10'd217;
    localparam logic [OffW-1:0] OffZReset = 10'd181;

    localparam logic [1:0] CfgOffX = 2'd0;
    localparam logic [1:0] CfgOffY = 2'd1;
    localparam logic [1:0] CfgOffZ = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        t_op              op;
        logic             first;
        logic             oor;
        logic [VoxW-1:0]  vx;
        logic [VoxW-1:0]  vy;
        logic [VoxW-1:0]  vz;
    } t_cmd;

    // Truncate a Q12.4 value toward zero and subtract it from an offset.
    function automatic logic signed [17:0] voxel_index(input logic [OffW-1:0] off,
                                                       input logic [CoordW-1:0] c);
        logic signed [CoordW-1:0] s;
        logic signed [CoordW-1:0] mag;
        logic signed [CoordW-1:0] t;
        begin
            s   = $signed(c);
            mag = s[CoordW-1] ? -s : s;
            t   = mag >>> 4;
            if (s[CoordW-1]) begin
                t = -t;
            end
            voxel_index = $signed({8'd0, off}) - 18'(s[CoordW-1] ? -$signed({1'b0, mag[CoordW-1:4]})
                                                 : $signed({1'b0, t[CoordW-5:0]}));
        end
    endfunction

endpackage

// ===== rtl/track_voxel_visit_density.sv =====
// ----------------------------------------------------------------------------
// Track voxel visit density
// Builds a saturating visit-count volume from track points.
// ----------------------------------------------------------------------------
// Usage: requests arrive on the input valid/ready channel with a mode (add
// point, read voxel, clear, no operation). Each request yields exactly one
// result on the output valid/ready channel. The user is to write offsets on
// the plain configuration port only while the block is idle; the block
// itself does not enforce this. A front part classifies each request,
// computing voxel indices and range flags, and places it in a two-entry
// queue; a back part performs the memory read-modify-write, the running
// maximum and the normalisation. The back part reads the counter of a queued
// add or read, updates it and then normalises it with the one-bit-per-cycle
// Q1.15 divider before the result is registered; the division is skipped
// while the maximum is still zero, an out-of-range request skips update and
// division, and a clear or no-operation goes straight to the result. A clear
// then walks the whole store, one counter per cycle, after its result is
// issued. Reset: offsets return to their defaults and the store is swept to
// zero, during which at most two requests queue. A stalled receiver holds
// the result register; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module track_voxel_visit_density
    import tvvd_pkg::*;
#(
    parameter int DIM_X      = DefDimX,
    parameter int DIM_Y      = DefDimY,
    parameter int DIM_Z      = DefDimZ,
    parameter int COUNT_BITS = DefCountBits
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [OffW-1:0]   i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic              i_first_point,
    input  logic [CoordW-1:0] i_coord_x,
    input  logic [CoordW-1:0] i_coord_y,
    input  logic [CoordW-1:0] i_coord_z,
    input  logic [ReadW-1:0]  i_read_x,
    input  logic [ReadW-1:0]  i_read_y,
    input  logic [ReadW-1:0]  i_read_z,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_counted,
    output logic              o_out_of_range,
    output logic [OutW-1:0]   o_raw_count,
    output logic [OutW-1:0]   o_normalized_value,
    output logic [OutW-1:0]   o_peak_count
);

    logic [OffW-1:0] r_off_x, r_off_y, r_off_z;
    logic            w_cmd_valid, w_cmd_ready;
    t_cmd            w_cmd;

    // Offset registers; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= OffXReset;
            r_off_y <= OffYReset;
            r_off_z <= OffZReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgOffX: r_off_x <= i_cfg_data;
                CfgOffY: r_off_y <= i_cfg_data;
                CfgOffZ: r_off_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tvvd_front #(.DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_first_point,
        .i_coord_x, .i_coord_y, .i_coord_z, .i_read_x, .i_read_y, .i_read_z,
        .i_off_x(r_off_x), .i_off_y(r_off_y), .i_off_z(r_off_z),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_ready(w_cmd_ready)
    );

    tvvd_back #(.DIM_X(DIM_X), .DIM_Y(DIM_Y), .DIM_Z(DIM_Z),
                .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd),
        .o_cmd_ready(w_cmd_ready), .o_valid, .i_ready, .o_counted, .o_out_of_range,
        .o_raw_count, .o_normalized_value, .o_peak_count
    );

endmodule

// ===== rtl/tvvd_front.sv =====
// ----------------------------------------------------------------------------
// Track voxel density front end
// Accepts requests, computes voxel indices and range flags, queues commands.
// ----------------------------------------------------------------------------
module tvvd_front
    import tvvd_pkg::*;
#(
    parameter int DIM_X = DefDimX,
    parameter int DIM_Y = DefDimY,
    parameter int DIM_Z = DefDimZ
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic              i_first_point,
    input  logic [CoordW-1:0] i_coord_x,
    input  logic [CoordW-1:0] i_coord_y,
    input  logic [CoordW-1:0] i_coord_z,
    input  logic [ReadW-1:0]  i_read_x,
    input  logic [ReadW-1:0]  i_read_y,
    input  logic [ReadW-1:0]  i_read_z,
    input  logic [OffW-1:0]   i_off_x,
    input  logic [OffW-1:0]   i_off_y,
    input  logic [OffW-1:0]   i_off_z,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_ready
);

    // Two-entry queue.
    t_cmd        r_q [2];
    logic        r_wp, n_wp, r_rp, n_rp;
    logic [1:0]  r_cnt, n_cnt;
    t_cmd        w_cmd;
    logic signed [17:0] w_ix, w_iy, w_iz;
    logic        w_push, w_pop;

    always_comb begin
        w_ix = voxel_index(i_off_x, i_coord_x);
        w_iy = voxel_index(i_off_y, i_coord_y);
        w_iz = voxel_index(i_off_z, i_coord_z);
        w_cmd.op    = t_op'(i_mode);
        w_cmd.first = i_first_point;
        if (t_op'(i_mode) == OP_READ) begin
            w_cmd.vx  = VoxW'(i_read_x);
            w_cmd.vy  = VoxW'(i_read_y);
            w_cmd.vz  = VoxW'(i_read_z);
            w_cmd.oor = (32'(i_read_x) >= DIM_X) || (32'(i_read_y) >= DIM_Y)
                     || (32'(i_read_z) >= DIM_Z);
        end else begin
            w_cmd.vx  = w_ix[VoxW-1:0];
            w_cmd.vy  = w_iy[VoxW-1:0];
            w_cmd.vz  = w_iz[VoxW-1:0];
            w_cmd.oor = w_ix < 0 || w_ix >= 18'(DIM_X) || w_iy < 0 || w_iy >= 18'(DIM_Y)
                     || w_iz < 0 || w_iz >= 18'(DIM_Z);
        end
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_push      = i_valid && o_ready;
    assign w_pop       = o_cmd_valid && i_cmd_ready;

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ w_pop;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

endmodule

// ===== rtl/tvvd_back.sv =====
// ----------------------------------------------------------------------------
// Track voxel density back end
// Memory read-modify-write, running maximum, clear sweep and Q1.15 divider.
// ----------------------------------------------------------------------------
module tvvd_back
    import tvvd_pkg::*;
#(
    parameter int DIM_X      = DefDimX,
    parameter int DIM_Y      = DefDimY,
    parameter int DIM_Z      = DefDimZ,
    parameter int COUNT_BITS = DefCountBits
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_cmd_ready,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_counted,
    output logic            o_out_of_range,
    output logic [OutW-1:0] o_raw_count,
    output logic [OutW-1:0] o_normalized_value,
    output logic [OutW-1:0] o_peak_count
);

    localparam int Voxels = DIM_X * DIM_Y * DIM_Z;
    localparam int AddrW  = $clog2(Voxels);
    localparam int CntW   = COUNT_BITS;
    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
    localparam int DivW   = CntW + 16;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RMW, S_DIV, S_OUT
    } t_state;

    logic [CntW-1:0] r_mem [Voxels];

    t_state          r_state;
    t_cmd            r_cmd;
    logic [AddrW-1:0] r_addr;
    logic [AddrW:0]  r_clr;
    logic [CntW-1:0] r_rd, r_raw, r_max;
    logic [VoxW-1:0] r_lx, r_ly, r_lz;
    logic            r_open, r_counted;
    logic [DivW-1:0] r_num, r_quo;
    logic [CntW:0]   r_rem;
    logic [5:0]      r_bit;
    logic [CntW:0]   w_trial;
    logic [AddrW-1:0] w_addr;
    logic            w_same, w_open_eff;
    logic [CntW-1:0] w_new;

    assign o_cmd_ready = (r_state == S_IDLE);

    always_comb begin
        w_addr = AddrW'((32'(i_cmd.vx) * DIM_Y + 32'(i_cmd.vy)) * DIM_Z + 32'(i_cmd.vz));
        w_open_eff = r_open && !r_cmd.first;
        w_same = w_open_eff && r_cmd.vx == r_lx && r_cmd.vy == r_ly && r_cmd.vz == r_lz;
        w_new  = (r_rd < CntMax) ? r_rd + 1'b1 : r_rd;
        w_trial = {r_rem[CntW-1:0], r_num[DivW-1]} - {1'b0, r_max};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_max   <= '0;
            r_open  <= 1'b0;
            r_lx    <= '0;
            r_ly    <= '0;
            r_lz    <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_mem[r_clr[AddrW-1:0]] <= '0;
                    if (r_clr == (AddrW+1)'(Voxels - 1)) begin
                        r_state <= S_IDLE;
                    end
                    r_clr <= r_clr + 1'b1;
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd  <= i_cmd;
                        r_addr <= w_addr;
                        r_rd   <= r_mem[w_addr];
                        case (i_cmd.op)
                            OP_CLEAR: begin
                                r_max   <= '0;
                                r_open  <= 1'b0;
                                r_clr   <= '0;
                                r_raw   <= '0;
                                r_counted <= 1'b0;
                                r_quo   <= '0;
                                r_state <= S_OUT;
                            end
                            OP_NOP: begin
                                r_raw   <= '0;
                                r_counted <= 1'b0;
                                r_quo   <= '0;
                                r_state <= S_OUT;
                            end
                            default: begin
                                if (i_cmd.op == OP_ADD && i_cmd.first) begin
                                    r_open <= 1'b0;
                                end
                                r_state <= S_RMW;
                            end
                        endcase
                    end
                end
                S_RMW: begin
                    if (r_cmd.oor) begin
                        r_counted <= 1'b0;
                        r_raw   <= '0;
                        r_quo   <= '0;
                        r_state <= S_OUT;
                    end else begin
                        if (r_cmd.op == OP_ADD && !w_same) begin
                            r_lx <= r_cmd.vx;
                            r_ly <= r_cmd.vy;
                            r_lz <= r_cmd.vz;
                            r_open <= 1'b1;
                        end
                        if (r_cmd.op == OP_ADD && !w_same && r_rd < CntMax) begin
                            r_mem[r_addr] <= w_new;
                            r_counted <= 1'b1;
                            r_raw <= w_new;
                            if (w_new > r_max) begin
                                r_max <= w_new;
                            end
                        end else begin
                            r_counted <= 1'b0;
                            r_raw     <= r_rd;
                        end
                        r_state <= S_DIV;
                        r_bit   <= '0;
                        r_rem   <= '0;
                        r_quo   <= '0;
                        r_num   <= '0;
                    end
                end
                S_DIV: begin
                    // Restoring division of raw*32768 by the maximum, one bit a cycle.
                    if (r_bit == 6'd0) begin
                        r_num <= {1'b0, r_raw, 15'd0};
                        r_bit <= 6'd1;
                        if (r_max == '0) begin
                            r_quo   <= '0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_num <= r_num << 1;
                        if (!w_trial[CntW]) begin
                            r_rem <= w_trial;
                            r_quo <= {r_quo[DivW-2:0], 1'b1};
                        end else begin
                            r_rem <= {r_rem[CntW-1:0], r_num[DivW-1]};
                            r_quo <= {r_quo[DivW-2:0], 1'b0};
                        end
                        if (r_bit == 6'(DivW)) begin
                            r_state <= S_OUT;
                        end
                        r_bit <= r_bit + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid            <= 1'b1;
                        o_counted          <= r_counted;
                        o_out_of_range     <= r_cmd.oor && (r_cmd.op == OP_ADD
                                              || r_cmd.op == OP_READ);
                        o_raw_count        <= OutW'(r_raw);
                        o_normalized_value <= OutW'(r_quo);
                        o_peak_count       <= OutW'(r_max);
                        r_state <= (r_cmd.op == OP_CLEAR) ? S_CLEAR : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (o_valid && i_ready && !(r_state == S_OUT)) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== tb/track_voxel_visit_density_tb.sv =====
// ----------------------------------------------------------------------------
// Track voxel visit density testbench
// Drives point, read, clear and no-operation requests through the block under
// random idling on both channels, predicts every result with a behavioural
// model of the voxel store and checks each result field by field.
// ----------------------------------------------------------------------------
module track_voxel_visit_density_tb
    import tvvd_pkg::*;
();

    localparam int Dim      = 64;
    localparam int CountMax = 65535;
    // An index the block has no register for; writes to it must be ignored.
    localparam logic [1:0] CfgSpare = 2'd3;
    // Cycles allowed after the last result before a register write or the end.
    localparam int SettleCycles = 60;

    typedef struct {
        t_op              mode;
        logic             first;
        logic [CoordW-1:0] cx;
        logic [CoordW-1:0] cy;
        logic [CoordW-1:0] cz;
        logic [ReadW-1:0] rx;
        logic [ReadW-1:0] ry;
        logic [ReadW-1:0] rz;
    } t_voxel_req;

    typedef struct {
        logic            counted;
        logic            oor;
        logic [OutW-1:0] raw;
        logic [OutW-1:0] norm;
        logic [OutW-1:0] peak;
    } t_voxel_res;

    // Behavioural copy of the density volume and the queue of results it
    // predicts, oldest first.
    class t_density_scoreboard;
        int unsigned off_x = OffXReset;
        int unsigned off_y = OffYReset;
        int unsigned off_z = OffZReset;
        int          counts[int];
        int          last_x, last_y, last_z;
        bit          track_open;
        int          peak;
        t_voxel_res  awaited[$];
        int          mismatches;
        int          n_add, n_read, n_clear, n_nop, n_counted, n_oor, n_checked;

        function void set_offset(logic [1:0] idx, logic [OffW-1:0] val);
            case (idx)
                CfgOffX: off_x = val;
                CfgOffY: off_y = val;
                CfgOffZ: off_z = val;
                default: ;
            endcase
        endfunction

        // Integer part of a Q12.4 value, truncated toward zero.
        function int whole_part(logic [CoordW-1:0] c);
            int s;
            s = $signed(c);
            return (s < 0) ? -((-s) >> 4) : (s >> 4);
        endfunction

        function int count_at(int a);
            return counts.exists(a) ? counts[a] : 0;
        endfunction

        function logic [OutW-1:0] ratio(int c);
            longint q;
            if (peak == 0) begin
                return '0;
            end
            q = (longint'(c) * 32768) / peak;
            return OutW'(q);
        endfunction

        function void note_request(t_voxel_req r);
            t_voxel_res e;
            int vx, vy, vz, a, c;
            bit same;
            e = '{default: '0};
            case (r.mode)
                OP_ADD: begin
                    n_add++;
                    vx = int'(off_x) - whole_part(r.cx);
                    vy = int'(off_y) - whole_part(r.cy);
                    vz = int'(off_z) - whole_part(r.cz);
                    if (r.first) begin
                        track_open = 0;
                    end
                    if (vx < 0 || vx >= Dim || vy < 0 || vy >= Dim || vz < 0 || vz >= Dim) begin
                        e.oor = 1'b1;
                        n_oor++;
                    end else begin
                        a = (vx * Dim + vy) * Dim + vz;
                        same = track_open && vx == last_x && vy == last_y && vz == last_z;
                        if (!same) begin
                            c = count_at(a);
                            if (c < CountMax) begin
                                c++;
                                counts[a] = c;
                                e.counted = 1'b1;
                                n_counted++;
                                if (c > peak) begin
                                    peak = c;
                                end
                            end
                            last_x = vx;
                            last_y = vy;
                            last_z = vz;
                            track_open = 1;
                        end
                        e.raw  = OutW'(count_at(a));
                        e.norm = ratio(count_at(a));
                    end
                end
                OP_READ: begin
                    // Six-bit read indices always fall inside a 64-wide volume.
                    n_read++;
                    a = (int'(r.rx) * Dim + int'(r.ry)) * Dim + int'(r.rz);
                    e.raw  = OutW'(count_at(a));
                    e.norm = ratio(count_at(a));
                end
                OP_CLEAR: begin
                    n_clear++;
                    counts.delete();
                    peak = 0;
                    track_open = 0;
                end
                default: n_nop++;
            endcase
            e.peak = OutW'(peak);
            awaited.insert(awaited.size(), e);
        endfunction

        function void check_result(t_voxel_res got);
            t_voxel_res e;
            n_checked++;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with no request outstanding", n_checked);
                end
                return;
            end
            e = awaited.pop_front();
            if (got.counted !== e.counted || got.oor !== e.oor || got.raw !== e.raw ||
                got.norm !== e.norm || got.peak !== e.peak) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d: expected cnt=%0d oor=%0d raw=%0d norm=%0d peak=%0d",
                             n_checked, e.counted, e.oor, e.raw, e.norm, e.peak);
                    $display("result %0d:   actual cnt=%0d oor=%0d raw=%0d norm=%0d peak=%0d",
                             n_checked, got.counted, got.oor, got.raw, got.norm, got.peak);
                end
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [OffW-1:0]   i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_mode;
    logic              i_first_point;
    logic [CoordW-1:0] i_coord_x, i_coord_y, i_coord_z;
    logic [ReadW-1:0]  i_read_x, i_read_y, i_read_z;
    logic              o_valid;
    logic              i_ready;
    logic              o_counted;
    logic              o_out_of_range;
    logic [OutW-1:0]   o_raw_count, o_normalized_value, o_peak_count;

    t_density_scoreboard density_sb = new();

    // Cycles for which the receiver must refuse results; set by the stimulus,
    // counted down by the receiver.
    int hold_off_req;

    // Hot corner of the volume that tracks wander in, and the open track.
    int hot_x, hot_y, hot_z;
    int trk_x, trk_y, trk_z;
    int trk_left;

    track_voxel_visit_density uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_mode             (i_mode),
        .i_first_point      (i_first_point),
        .i_coord_x          (i_coord_x),
        .i_coord_y          (i_coord_y),
        .i_coord_z          (i_coord_z),
        .i_read_x           (i_read_x),
        .i_read_y           (i_read_y),
        .i_read_z           (i_read_z),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_counted          (o_counted),
        .o_out_of_range     (o_out_of_range),
        .o_raw_count        (o_raw_count),
        .o_normalized_value (o_normalized_value),
        .o_peak_count       (o_peak_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The run is bounded by the reset sweep, two full clears and the
    // requests themselves; this limit is several times that.
    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    // Results are taken at the rising edge on which valid and ready are both
    // high, and handed to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            density_sb.check_result('{o_counted, o_out_of_range, o_raw_count,
                                      o_normalized_value, o_peak_count});
        end
    end

    // The receiver changes its stall pattern every so often: always ready,
    // mostly ready, or mostly stalled. A requested hold-off overrides it.
    initial begin
        int style;
        int style_left;
        style = 0;
        style_left = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req > 0) begin
                i_ready = 1'b0;
                hold_off_req--;
            end else begin
                if (style_left <= 0) begin
                    style = $urandom_range(2);
                    style_left = $urandom_range(200, 20);
                end
                style_left--;
                case (style)
                    0: i_ready = 1'b1;
                    1: i_ready = ($urandom_range(99) < 75);
                    default: i_ready = ($urandom_range(99) < 25);
                endcase
            end
        end
    end

    // A Q12.4 coordinate whose truncated value, subtracted from the offset,
    // lands on the given voxel index. Any fraction is used.
    function automatic logic [CoordW-1:0] coord_for(int idx, int unsigned off);
        int t, v;
        t = int'(off) - idx;
        if (t > 0) begin
            v = t * 16 + $urandom_range(15);
        end else if (t < 0) begin
            v = t * 16 - $urandom_range(15);
        end else begin
            v = $urandom_range(30) - 15;
        end
        return CoordW'(v);
    endfunction

    function automatic t_voxel_req point_at(logic first, int x, int y, int z);
        t_voxel_req r;
        r = '{mode: OP_ADD, first: first, default: '0};
        r.cx = coord_for(x, density_sb.off_x);
        r.cy = coord_for(y, density_sb.off_y);
        r.cz = coord_for(z, density_sb.off_z);
        r.rx = ReadW'($urandom);
        r.ry = ReadW'($urandom);
        r.rz = ReadW'($urandom);
        return r;
    endfunction

    function automatic t_voxel_req read_at(int x, int y, int z);
        t_voxel_req r;
        r = '{mode: OP_READ, first: 1'($urandom), default: '0};
        r.cx = CoordW'($urandom);
        r.cy = CoordW'($urandom);
        r.cz = CoordW'($urandom);
        r.rx = ReadW'(x);
        r.ry = ReadW'(y);
        r.rz = ReadW'(z);
        return r;
    endfunction

    function automatic t_voxel_req nop_req();
        t_voxel_req r;
        r = read_at($urandom_range(63), $urandom_range(63), $urandom_range(63));
        r.mode = OP_NOP;
        return r;
    endfunction

    // Mostly well-formed tracks that revisit a small hot cube, so counters
    // climb and repeated voxels occur; the rest are reads, no-operations and
    // points with arbitrary coordinates.
    function automatic t_voxel_req random_request();
        t_voxel_req r;
        int pick;
        logic first;
        pick = $urandom_range(99);
        if (pick < 12) begin
            if ($urandom_range(1)) begin
                r = read_at(hot_x + $urandom_range(3), hot_y + $urandom_range(3),
                            hot_z + $urandom_range(3));
            end else begin
                r = read_at($urandom_range(63), $urandom_range(63), $urandom_range(63));
            end
        end else if (pick < 16) begin
            r = nop_req();
        end else if (pick < 24) begin
            r = point_at(1'($urandom), 0, 0, 0);
            r.cx = CoordW'($urandom);
            r.cy = CoordW'($urandom);
            r.cz = CoordW'($urandom);
        end else begin
            first = (trk_left <= 0);
            if (first) begin
                trk_left = $urandom_range(12, 2);
            end
            trk_left--;
            if (first || $urandom_range(99) >= 30) begin
                trk_x = hot_x + $urandom_range(3);
                trk_y = hot_y + $urandom_range(3);
                trk_z = hot_z + $urandom_range(3);
            end
            if ($urandom_range(99) < 4) begin
                // A stray point just off one face of the volume.
                r = point_at(first, $urandom_range(1) ? -1 : Dim, trk_y, trk_z);
            end else begin
                r = point_at(first, trk_x, trk_y, trk_z);
            end
        end
        return r;
    endfunction

    // Present one request and hold it until accepted.
    task automatic send_request(t_voxel_req r);
        @(negedge i_clk);
        i_valid       = 1'b1;
        i_mode        = r.mode;
        i_first_point = r.first;
        i_coord_x     = r.cx;
        i_coord_y     = r.cy;
        i_coord_z     = r.cz;
        i_read_x      = r.rx;
        i_read_y      = r.ry;
        i_read_z      = r.rz;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        density_sb.note_request(r);
    endtask

    task automatic idle_sender(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // Stop offering requests until every predicted result has come back, then
    // let the block settle.
    task automatic drain();
        idle_sender(1);
        while (density_sb.awaited.size() != 0) begin
            @(posedge i_clk);
        end
        idle_sender(SettleCycles);
    endtask

    task automatic write_offset(logic [1:0] idx, logic [OffW-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        density_sb.set_offset(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_burst_run(int count);
        int sent;
        int burst;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(20, 1);
            repeat (burst) begin
                send_request(random_request());
                sent++;
            end
            // Roughly a third of bursts run straight into the next one.
            if ($urandom_range(2) != 0) begin
                idle_sender($urandom_range(8, 1));
            end
        end
    endtask

    initial begin
        int ox, oy, oz;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CfgOffX;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_mode        = OP_NOP;
        i_first_point = 1'b0;
        i_coord_x     = '0;
        i_coord_y     = '0;
        i_coord_z     = '0;
        i_read_x      = '0;
        i_read_y      = '0;
        i_read_z      = '0;
        hold_off_req  = 0;
        trk_left      = 0;
        hot_x = 0;
        hot_y = 0;
        hot_z = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed requests at the reset offsets. The block sweeps its store
        // after reset, so the first two requests queue and the third waits for ready.
        send_request(point_at(1'b1, 0, 0, 0));
        send_request(point_at(1'b0, 0, 0, 0));      // same voxel, not counted
        send_request(point_at(1'b1, 0, 0, 0));      // new track counts again
        send_request(point_at(1'b0, 63, 63, 63));
        send_request(point_at(1'b0, -1, 5, 5));     // just below the volume
        send_request(point_at(1'b0, 5, Dim, 5));    // just above the volume
        send_request(point_at(1'b0, 5, 5, -1));
        send_request(point_at(1'b0, 63, 63, 63));   // last voxel kept across drops
        send_request(point_at(1'b1, 0, 0, 0));
        send_request('{OP_ADD, 1'b0, 16'h7FFF, 16'h8000, 16'h7FFF, 6'h3F, 6'h00, 6'h3F});
        send_request('{OP_ADD, 1'b1, 16'h8000, 16'h7FFF, 16'h8000, 6'h00, 6'h3F, 6'h00});
        send_request(point_at(1'b1, int'(OffXReset), 0, 0));  // fraction-only x
        send_request(read_at(0, 0, 0));
        send_request(read_at(63, 63, 63));
        send_request(read_at(5, 6, 7));             // never written
        send_request(nop_req());
        send_request('{OP_CLEAR, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'h3F, 6'h3F, 6'h3F});
        send_request(read_at(0, 0, 0));
        send_request(point_at(1'b0, 0, 0, 0));      // track forgotten by the clear
        send_request(point_at(1'b0, 0, 0, 1));
        send_request(nop_req());
        drain();

        // Random phases, each under its own offsets and hot corner.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    ox = 0;
                    oy = 0;
                    oz = 0;
                end
                1: begin
                    ox = 1023;
                    oy = 1023;
                    oz = 1023;
                end
                5: begin
                    ox = OffXReset;
                    oy = OffYReset;
                    oz = OffZReset;
                end
                default: begin
                    ox = $urandom_range(1023);
                    oy = $urandom_range(1023);
                    oz = $urandom_range(1023);
                end
            endcase
            write_offset(CfgOffX, OffW'(ox));
            write_offset(CfgOffY, OffW'(oy));
            write_offset(CfgOffZ, OffW'(oz));
            if (phase == 0) begin
                write_offset(CfgSpare, OffW'($urandom));
            end
            hot_x = (phase == 1) ? 60 : $urandom_range(60);
            hot_y = (phase == 0) ? 0 : $urandom_range(60);
            hot_z = $urandom_range(60);
            trk_left = 0;

            if (phase == 2) begin
                // Receiver holds off for a long stretch while requests keep
                // coming, so the queue fills and the input stalls.
                hold_off_req = 400;
                repeat (30) send_request(random_request());
            end
            random_burst_run(phase == 2 ? 250 : 280);
            if (phase == 3) begin
                // One more clear mid-phase, then tracks start afresh.
                send_request('{OP_CLEAR, 1'b1, 16'h0000, 16'h0000, 16'h0000,
                               6'h00, 6'h00, 6'h00});
                random_burst_run(40);
            end
            drain();
        end

        $display("Covered %0d adds (%0d counted, %0d out of range), %0d reads, %0d clears,",
                 density_sb.n_add, density_sb.n_counted, density_sb.n_oor,
                 density_sb.n_read, density_sb.n_clear);
        $display("%0d no-operations and %0d checked results, with %0d mismatches.",
                 density_sb.n_nop, density_sb.n_checked, density_sb.mismatches);
        if (density_sb.mismatches == 0 && density_sb.awaited.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
